FILE: rtl/core/seam_carving_forward_energy_dp_defines.svh
// ============================================================================
// Seam finder assertion macros
// Concurrent check wrappers; compiled out when NO_ASSERTIONS is defined.
// ============================================================================
`ifndef SEAM_CARVING_FORWARD_ENERGY_DP_DEFINES_SVH
`define SEAM_CARVING_FORWARD_ENERGY_DP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SCFE_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("seam finder check failed");
// next-cycle implication
`define SCFE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("seam finder check failed");
`else
`define SCFE_ASSERT(label, clk, rstn, ante, cons)
`define SCFE_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/core/seamfe_pkg.sv
// ============================================================================
// Seam finder package
// Shared pixel, control types and parent codes of the forward-energy seam finder.
// ============================================================================
`default_nettype none

package seamfe_pkg;

    localparam int CFG_BITS = 10;

    // register indexes (address bit 2)
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // parent direction codes
    localparam logic [1:0] PARENT_LEFT  = 2'd0;
    localparam logic [1:0] PARENT_UP    = 2'd1;
    localparam logic [1:0] PARENT_RIGHT = 2'd2;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic first_row;
        logic has_left;
        logic has_right;
    } settle_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/seamfe_settle.sv
// ============================================================================
// Seam finder settle unit
// Forward-energy costs of one pixel and choice of its cheapest parent.
// ============================================================================
`default_nettype none

module seamfe_settle import seamfe_pkg::*; #(
    parameter int COST_BITS = 32
) (
    input  settle_ctl_t            ctl,
    input  rgb_t                   left_px,
    input  rgb_t                   right_px,
    input  rgb_t                   up_px,
    input  logic [COST_BITS-1:0]   prev_left,
    input  logic [COST_BITS-1:0]   prev_up,
    input  logic [COST_BITS-1:0]   prev_right,
    output logic [COST_BITS-1:0]   cost,
    output logic [1:0]             code
);

    localparam int DIFF_BITS = 18;

    // sum of squared channel differences
    function automatic logic [DIFF_BITS-1:0] pix_diff(input rgb_t p, input rgb_t q);
        logic [2:0][7:0]      pa;
        logic [2:0][7:0]      qa;
        logic [7:0]           mag;
        logic [DIFF_BITS-1:0] sum;
        pa  = p;
        qa  = q;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mag = (pa[i] >= qa[i]) ? (pa[i] - qa[i]) : (qa[i] - pa[i]);
            sum = sum + DIFF_BITS'({8'd0, mag} * {8'd0, mag});
        end
        return sum;
    endfunction

    function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                     input logic [COST_BITS-1:0] b);
        logic [COST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_BITS] ? '1 : s[COST_BITS-1:0];
    endfunction

    logic [DIFF_BITS-1:0] row_diff;
    logic [DIFF_BITS-1:0] up_left;
    logic [DIFF_BITS-1:0] up_right;
    logic [DIFF_BITS:0]   step_left;
    logic [DIFF_BITS:0]   step_right;
    logic [COST_BITS-1:0] cand_l;
    logic [COST_BITS-1:0] cand_u;
    logic [COST_BITS-1:0] cand_r;

    assign row_diff   = pix_diff(left_px, right_px);
    assign up_left    = pix_diff(up_px, left_px);
    assign up_right   = pix_diff(up_px, right_px);
    assign step_left  = {1'b0, row_diff} + {1'b0, up_left};
    assign step_right = {1'b0, row_diff} + {1'b0, up_right};

    assign cand_l = sat_add(prev_left, COST_BITS'(step_left));
    assign cand_u = sat_add(prev_up, COST_BITS'(row_diff));
    assign cand_r = sat_add(prev_right, COST_BITS'(step_right));

    // strict compares: ties stay left, then up
    always_comb begin
        if (ctl.first_row) begin
            cost = COST_BITS'(row_diff);
            code = PARENT_UP;
        end else begin
            if (ctl.has_left) begin
                cost = cand_l;
                code = PARENT_LEFT;
            end else begin
                cost = cand_u;
                code = PARENT_UP;
            end
            if (ctl.has_left && (cand_u < cost)) begin
                cost = cand_u;
                code = PARENT_UP;
            end
            if (ctl.has_right && (cand_r < cost)) begin
                cost = cand_r;
                code = PARENT_RIGHT;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/seam_carving_forward_energy_dp.sv
// ============================================================================
// Forward-energy vertical seam finder
// Usage: write image_width (0x0) and image_height (0x4) over APB while idle;
// each write restarts loading. Send pixels (s_func = 0) in raster order, then
// seam steps (s_func = 1); each step returns one transaction with the seam
// column of one row, bottom row first, m_last on row 0, then it replays.
// A step sent before the image is complete returns m_status = 1.
// Flow: a step transaction is accepted into an input register and, once the
// output register is free, worked into the output register, which drives
// m_valid.
// Throughput: one transaction per cycle while results are taken, except
// after a pixel closing a row (other than in a one-column image), since the
// single settle unit handles one column per cycle and that pixel settles two.
// Reset: control registers return to their defaults; payload registers,
// pixel, cost and parent memories are not cleared and need no clearing pass.
// A stalled m_ready holds the result; a following step waits in the input
// register and s_ready stays low until the held result is taken.
// ============================================================================
`default_nettype none
`include "seam_carving_forward_energy_dp_defines.svh"

module seam_carving_forward_energy_dp import seamfe_pkg::*; #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int COST_BITS  = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [7:0]  s_red,
    input  wire logic [7:0]  s_green,
    input  wire logic [7:0]  s_blue,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [8:0]       m_seam_column,
    output logic [8:0]       m_seam_row,
    output logic [31:0]      m_seam_cost,
    output logic             m_last,
    output logic             m_status
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [1:0] {PH_LOADING, PH_TRACING} phase_t;

    function automatic logic [WW-1:0] clamp_width(input logic [CFG_BITS-1:0] v);
        if (v == '0) return WW'(1);
        else if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
        else return WW'(v);
    endfunction

    function automatic logic [HW-1:0] clamp_height(input logic [CFG_BITS-1:0] v);
        if (v == '0) return HW'(1);
        else if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
        else return HW'(v);
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    logic [CFG_BITS-1:0]  width_cfg_reg, width_cfg_next;
    logic [CFG_BITS-1:0]  height_cfg_reg, height_cfg_next;
    logic [WW-1:0]        eff_w_reg, eff_w_next;
    logic [HW-1:0]        eff_h_reg, eff_h_next;

    logic                 in_v_reg, in_v_next;
    logic                 in_func_reg;
    rgb_t                 in_px_reg;
    logic                 tail_reg, tail_next;
    rgb_t                 recent0_reg, recent0_next;
    rgb_t                 recent1_reg, recent1_next;
    logic [CW-1:0]        load_col_reg, load_col_next;
    logic [RW-1:0]        load_row_reg, load_row_next;
    logic [COST_BITS:0]   best_cost_reg, best_cost_next;
    logic [CW-1:0]        best_col_reg, best_col_next;
    logic [CW-1:0]        trace_col_reg, trace_col_next;
    logic [RW-1:0]        trace_row_reg, trace_row_next;
    phase_t               phase_reg, phase_next;
    logic                 m_valid_reg, m_valid_next;

    logic [8:0]           m_col_reg, m_row_reg;
    logic [31:0]          m_cost_reg;
    logic                 m_last_reg, m_status_reg;

    // previous-row cost window and first costs of the current row
    logic [COST_BITS-1:0] win_l_reg, win_m_reg, win_r_reg;
    logic [COST_BITS-1:0] first0_reg, first1_reg;
    logic [COST_BITS-1:0] cost_rd_reg;
    rgb_t                 above_rd_reg;
    logic [1:0]           par_rd_reg;

    // memories
    logic [COST_BITS-1:0] cost_mem   [2*(2**CW)];
    rgb_t                 above_mem  [2**CW];
    logic [1:0]           parent_mem [2**(RW+CW)];

    // ------------------------------------------------------------------
    // handshake and item decode
    // ------------------------------------------------------------------
    logic cfg_we, tracing, out_free, pix_go, seam_go, consume;
    logic [CW-1:0]      x_eff;
    logic [RW-1:0]      row_eff;
    logic [COST_BITS:0] best_base;
    logic               x_zero, x_last;

    assign cfg_we   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = 32'((paddr[2] == REG_IMAGE_HEIGHT) ? height_cfg_reg : width_cfg_reg);
    assign tracing  = (phase_reg == PH_TRACING);
    assign out_free = !m_valid_reg || m_ready;
    assign pix_go   = in_v_reg && !tail_reg && !in_func_reg;
    assign seam_go  = in_v_reg && !tail_reg && in_func_reg && out_free;
    assign consume  = pix_go || seam_go;
    assign s_ready  = !in_v_reg || consume;

    // a pixel after a finished image starts a new one
    assign x_eff     = tracing ? '0 : load_col_reg;
    assign row_eff   = tracing ? '0 : load_row_reg;
    assign best_base = tracing ? '1 : best_cost_reg;
    assign x_zero    = (x_eff == '0);
    assign x_last    = ((WW'(x_eff) + WW'(1)) >= eff_w_reg);

    // ------------------------------------------------------------------
    // settle source select
    // ------------------------------------------------------------------
    logic          settle_en, row_done;
    logic [CW-1:0] s_col;
    rgb_t          s_left, s_ctr, s_right;
    settle_ctl_t   s_ctl;
    logic [COST_BITS-1:0] s_cost;
    logic [1:0]    s_code;

    assign settle_en = tail_reg || (pix_go && (!x_zero || x_last));

    always_comb begin
        if (tail_reg) begin
            s_col    = load_col_reg;
            s_left   = (load_col_reg != '0) ? recent0_reg : recent1_reg;
            s_ctr    = recent1_reg;
            s_right  = recent1_reg;
            row_done = 1'b1;
        end else if (!x_zero) begin
            s_col    = CW'(32'(x_eff) - 1);
            s_left   = (s_col != '0) ? recent0_reg : recent1_reg;
            s_ctr    = recent1_reg;
            s_right  = in_px_reg;
            row_done = 1'b0;
        end else begin
            s_col    = '0;
            s_left   = in_px_reg;
            s_ctr    = in_px_reg;
            s_right  = in_px_reg;
            row_done = 1'b1;
        end
    end

    assign s_ctl.first_row = (row_eff == '0);
    assign s_ctl.has_left  = (s_col != '0);
    assign s_ctl.has_right = ((WW'(s_col) + WW'(1)) < eff_w_reg);

    seamfe_settle #(
        .COST_BITS (COST_BITS)
    ) u_settle (
        .ctl        (s_ctl),
        .left_px    (s_left),
        .right_px   (s_right),
        .up_px      (above_rd_reg),
        .prev_left  (win_l_reg),
        .prev_up    (win_m_reg),
        .prev_right (win_r_reg),
        .cost       (s_cost),
        .code       (s_code)
    );

    // ------------------------------------------------------------------
    // best column of the bottom row, row advance
    // ------------------------------------------------------------------
    logic               best_hit, image_done;
    logic [COST_BITS:0] best_cost_n;
    logic [CW-1:0]      best_col_n;
    logic [HW-1:0]      row_inc;

    assign row_inc     = HW'(row_eff) + HW'(1);
    assign best_hit    = settle_en && (row_inc == eff_h_reg) && ({1'b0, s_cost} < best_base);
    assign best_cost_n = best_hit ? {1'b0, s_cost} : best_base;
    assign best_col_n  = best_hit ? s_col : (tracing ? '0 : best_col_reg);
    assign image_done  = settle_en && row_done && (row_inc >= eff_h_reg);

    // result fields
    logic [COST_BITS+32:0] best_wide;
    logic [31:0]           best_sat;

    assign best_wide = (COST_BITS+33)'(best_cost_reg);
    assign best_sat  = (best_wide > (COST_BITS+33)'(32'hFFFF_FFFF)) ? '1 : best_wide[31:0];

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    logic par_rd_en;

    always_comb begin
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        eff_w_next      = eff_w_reg;
        eff_h_next      = eff_h_reg;
        in_v_next       = in_v_reg;
        tail_next       = tail_reg;
        recent0_next    = recent0_reg;
        recent1_next    = recent1_reg;
        load_col_next   = load_col_reg;
        load_row_next   = load_row_reg;
        best_cost_next  = best_cost_reg;
        best_col_next   = best_col_reg;
        trace_col_next  = trace_col_reg;
        trace_row_next  = trace_row_reg;
        phase_next      = phase_reg;
        m_valid_next    = m_valid_reg;
        par_rd_en       = 1'b0;

        // input register
        if (s_valid && s_ready) begin
            in_v_next = 1'b1;
        end else if (consume) begin
            in_v_next = 1'b0;
        end

        // pixel load
        if (pix_go) begin
            recent0_next   = recent1_reg;
            recent1_next   = in_px_reg;
            phase_next     = PH_LOADING;
            best_cost_next = best_cost_n;
            best_col_next  = best_col_n;
            load_row_next  = row_eff;
            load_col_next  = x_last ? x_eff : CW'(32'(x_eff) + 1);
            tail_next      = x_last && !x_zero;
        end

        // last column of a row
        if (tail_reg) begin
            tail_next      = 1'b0;
            best_cost_next = best_cost_n;
            best_col_next  = best_col_n;
        end

        // row complete
        if (settle_en && row_done) begin
            load_col_next = '0;
            if (image_done) begin
                load_row_next  = '0;
                phase_next     = PH_TRACING;
                trace_row_next = RW'(eff_h_reg - HW'(1));
                trace_col_next = best_col_n;
                par_rd_en      = 1'b1;
            end else begin
                load_row_next  = RW'(row_inc);
            end
        end

        // seam step
        if (seam_go) begin
            m_valid_next = 1'b1;
            if (tracing) begin
                par_rd_en = 1'b1;
                if (trace_row_reg == '0) begin
                    trace_row_next = RW'(eff_h_reg - HW'(1));
                    trace_col_next = best_col_reg;
                end else begin
                    trace_row_next = trace_row_reg - RW'(1);
                    if ((par_rd_reg == PARENT_LEFT) && (trace_col_reg != '0)) begin
                        trace_col_next = trace_col_reg - CW'(1);
                    end else if ((par_rd_reg == PARENT_RIGHT) &&
                                 ((WW'(trace_col_reg) + WW'(1)) < eff_w_reg)) begin
                        trace_col_next = trace_col_reg + CW'(1);
                    end
                end
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // register write restarts loading
        if (cfg_we) begin
            if (paddr[2] == REG_IMAGE_HEIGHT) begin
                height_cfg_next = pwdata[CFG_BITS-1:0];
                eff_h_next      = clamp_height(pwdata[CFG_BITS-1:0]);
            end else begin
                width_cfg_next  = pwdata[CFG_BITS-1:0];
                eff_w_next      = clamp_width(pwdata[CFG_BITS-1:0]);
            end
            load_col_next  = '0;
            load_row_next  = '0;
            best_cost_next = '1;
            best_col_next  = '0;
            phase_next     = PH_LOADING;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= CFG_BITS'(512);
            height_cfg_reg <= CFG_BITS'(512);
            eff_w_reg      <= clamp_width(CFG_BITS'(512));
            eff_h_reg      <= clamp_height(CFG_BITS'(512));
            in_v_reg       <= 1'b0;
            tail_reg       <= 1'b0;
            recent0_reg    <= '0;
            recent1_reg    <= '0;
            load_col_reg   <= '0;
            load_row_reg   <= '0;
            best_cost_reg  <= '1;
            best_col_reg   <= '0;
            trace_col_reg  <= '0;
            trace_row_reg  <= '0;
            phase_reg      <= PH_LOADING;
            m_valid_reg    <= 1'b0;
        end else begin
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
            eff_w_reg      <= eff_w_next;
            eff_h_reg      <= eff_h_next;
            in_v_reg       <= in_v_next;
            tail_reg       <= tail_next;
            recent0_reg    <= recent0_next;
            recent1_reg    <= recent1_next;
            load_col_reg   <= load_col_next;
            load_row_reg   <= load_row_next;
            best_cost_reg  <= best_cost_next;
            best_col_reg   <= best_col_next;
            trace_col_reg  <= trace_col_next;
            trace_row_reg  <= trace_row_next;
            phase_reg      <= phase_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg     <= s_func;
            in_px_reg.red   <= s_red;
            in_px_reg.green <= s_green;
            in_px_reg.blue  <= s_blue;
        end
        if (seam_go) begin
            m_col_reg    <= tracing ? 9'(trace_col_reg) : 9'd0;
            m_row_reg    <= tracing ? 9'(trace_row_reg) : 9'd0;
            m_cost_reg   <= tracing ? best_sat : 32'd0;
            m_last_reg   <= tracing && (trace_row_reg == '0);
            m_status_reg <= !tracing;
        end
        // slide the previous-row window; reload it at a row boundary
        if (settle_en) begin
            if (s_col == CW'(0)) first0_reg <= s_cost;
            if (s_col == CW'(1)) first1_reg <= s_cost;
            if (row_done) begin
                win_m_reg <= (s_col == CW'(0)) ? s_cost : first0_reg;
                win_r_reg <= (s_col == CW'(1)) ? s_cost : first1_reg;
            end else begin
                win_l_reg <= win_m_reg;
                win_m_reg <= win_r_reg;
                win_r_reg <= cost_rd_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // memories, read data registered with write bypass
    // ------------------------------------------------------------------
    logic [CW:0]    cost_waddr, cost_raddr;
    logic [CW-1:0]  above_raddr;
    logic [RW+CW-1:0] par_waddr, par_raddr;

    assign cost_waddr  = {row_eff[0], s_col};
    assign cost_raddr  = row_done ? {row_eff[0], CW'(2)} : {~row_eff[0], CW'(32'(s_col) + 3)};
    assign above_raddr = row_done ? '0 : CW'(32'(s_col) + 1);
    assign par_waddr   = {row_eff, s_col};
    assign par_raddr   = {trace_row_next, trace_col_next};

    // cumulative costs, two rows by row parity
    always_ff @(posedge aclk) begin
        if (settle_en) begin
            cost_mem[cost_waddr] <= s_cost;
            cost_rd_reg <= (cost_raddr == cost_waddr) ? s_cost : cost_mem[cost_raddr];
        end
    end

    // pixels of the row above
    always_ff @(posedge aclk) begin
        if (settle_en) begin
            above_mem[s_col] <= s_ctr;
            above_rd_reg <= (above_raddr == s_col) ? s_ctr : above_mem[above_raddr];
        end
    end

    // parent directions
    always_ff @(posedge aclk) begin
        if (settle_en) begin
            parent_mem[par_waddr] <= s_code;
        end
        if (par_rd_en) begin
            par_rd_reg <= (settle_en && (par_raddr == par_waddr)) ? s_code
                                                                   : parent_mem[par_raddr];
        end
    end

    // outputs
    assign m_valid       = m_valid_reg;
    assign m_seam_column = m_col_reg;
    assign m_seam_row    = m_row_reg;
    assign m_seam_cost   = m_cost_reg;
    assign m_last        = m_last_reg;
    assign m_status      = m_status_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `SCFE_ASSERT_NEXT(a_tail_one_cycle, aclk, aresetn, tail_reg, !tail_reg)
    `SCFE_ASSERT(a_col_in_image, aclk, aresetn, 1'b1, WW'(load_col_reg) < eff_w_reg)
    `SCFE_ASSERT(a_trace_clean, aclk, aresetn, phase_reg == PH_TRACING, load_col_reg == '0 && !tail_reg)
    `SCFE_ASSERT(a_early_result, aclk, aresetn, m_valid_reg && m_status_reg, m_cost_reg == '0 && !m_last_reg)

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the forward-energy vertical seam finder
// Streams RGB images of many sizes over the input channel and sends seam-step
// requests. A local model of the seam search predicts each result, and every
// result is checked field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import seamfe_pkg::*;;

    localparam int MAXW = 512;
    localparam int MAXH = 512;
    localparam longint unsigned COST_SAT = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [8:0]  column;
        logic [8:0]  row;
        logic [31:0] cost;
        logic        last;
        logic        status;
    } seam_result_t;

    typedef enum logic [1:0] {OP_CFG, OP_PIX, OP_STEP} row_op_e;

    typedef struct {
        row_op_e      op;
        logic         reg_idx;
        int           value;
        rgb_t         pix;
        bit           typed;
        seam_result_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0, s_func = 1'b0;
    logic [7:0]  s_red = '0, s_green = '0, s_blue = '0;
    logic        s_ready;
    logic        m_valid, m_ready = 1'b0;
    logic [8:0]  m_seam_column, m_seam_row;
    logic [31:0] m_seam_cost;
    logic        m_last, m_status;

    seam_carving_forward_energy_dp uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_red(s_red), .s_green(s_green), .s_blue(s_blue),
        .m_valid(m_valid), .m_ready(m_ready), .m_seam_column(m_seam_column),
        .m_seam_row(m_seam_row), .m_seam_cost(m_seam_cost), .m_last(m_last),
        .m_status(m_status)
    );

    always #6 aclk = ~aclk;

    // ---------------- seam search model ----------------
    logic [9:0]        cfg_width = 10'd512, cfg_height = 10'd512;
    logic [23:0]       px_above [MAXW];
    longint unsigned   cum_cost [2*MAXW];
    logic [1:0]        parent_dir [MAXW*MAXH];
    rgb_t              recent [2];
    int                ld_col, ld_row, best_col, tr_col, tr_row;
    longint unsigned   best_cost;
    bit                tracing;

    seam_result_t      expected_seams [$];
    int                err_count = 0;
    int                pixels_sent = 0, steps_sent = 0, results_seen = 0;
    int                idle_pct = 36;
    int                hold_req = 0;

    function automatic int eff_w();
        return cfg_width < 1 ? 1 : (cfg_width > MAXW ? MAXW : int'(cfg_width));
    endfunction

    function automatic int eff_h();
        return cfg_height < 1 ? 1 : (cfg_height > MAXH ? MAXH : int'(cfg_height));
    endfunction

    function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b);
        return (a + b > COST_SAT) ? COST_SAT : a + b;
    endfunction

    // sum of squared channel differences
    function automatic longint unsigned color_dist(rgb_t p, rgb_t q);
        int dr, dg, db;
        dr = int'(p.red) - int'(q.red);
        dg = int'(p.green) - int'(q.green);
        db = int'(p.blue) - int'(q.blue);
        return longint'(dr*dr + dg*dg + db*db);
    endfunction

    function automatic void restart_image();
        ld_col = 0;
        ld_row = 0;
        best_cost = '1;
        best_col = 0;
        tracing = 0;
    endfunction

    // cumulative cost and parent of column c in the row being loaded
    function automatic void settle_col(int c, rgb_t lft, rgb_t ctr, rgb_t rgt);
        int w, r, cur, prv;
        longint unsigned row_d, cost, cand;
        logic [1:0] dir;
        rgb_t up;
        bit have;
        w = eff_w();
        r = ld_row;
        row_d = color_dist(lft, rgt);
        cur = (r & 1) * MAXW;
        prv = ((r & 1) ^ 1) * MAXW;
        dir = PARENT_UP;
        if (r == 0) begin
            cost = row_d;
        end else begin
            up = px_above[c];
            cost = COST_SAT;
            have = 0;
            if (c > 0) begin
                cost = sat_add(cum_cost[prv+c-1], sat_add(row_d, color_dist(up, lft)));
                dir = PARENT_LEFT;
                have = 1;
            end
            cand = sat_add(cum_cost[prv+c], row_d);
            if (!have || cand < cost) begin
                cost = cand;
                dir = PARENT_UP;
            end
            if (c + 1 < w) begin
                cand = sat_add(cum_cost[prv+c+1], sat_add(row_d, color_dist(up, rgt)));
                if (cand < cost) begin
                    cost = cand;
                    dir = PARENT_RIGHT;
                end
            end
        end
        cum_cost[cur+c] = cost;
        parent_dir[r*MAXW+c] = dir;
        px_above[c] = ctr;
        if (r + 1 == eff_h() && cost < best_cost) begin
            best_cost = cost;
            best_col = c;
        end
    endfunction

    // advance the model by one accepted transaction
    function automatic bit seam_predict(bit func, rgb_t px, output seam_result_t res);
        int w, h, x, c, r;
        logic [1:0] dir;
        w = eff_w();
        h = eff_h();
        res = '0;
        if (!func) begin
            if (tracing) restart_image();
            x = ld_col;
            if (x > 0) settle_col(x-1, x > 1 ? recent[0] : recent[1], recent[1], px);
            recent[0] = recent[1];
            recent[1] = px;
            if (x + 1 >= w) begin
                settle_col(x, x > 0 ? recent[0] : recent[1], recent[1], recent[1]);
                ld_col = 0;
                ld_row++;
                if (ld_row >= h) begin
                    ld_row = 0;
                    tracing = 1;
                    tr_row = h - 1;
                    tr_col = best_col;
                end
            end else begin
                ld_col = x + 1;
            end
            return 0;
        end
        if (!tracing) begin
            res.status = 1'b1;
            return 1;
        end
        res.column = tr_col[8:0];
        res.row = tr_row[8:0];
        res.cost = best_cost > COST_SAT ? 32'hFFFF_FFFF : best_cost[31:0];
        res.last = (tr_row == 0);
        if (tr_row == 0) begin
            tr_row = h - 1;
            tr_col = best_col;
        end else begin
            r = tr_row;
            c = tr_col;
            dir = parent_dir[r*MAXW+c];
            if (dir == PARENT_LEFT && c > 0) c--;
            else if (dir == PARENT_RIGHT && c + 1 < w) c++;
            tr_col = c;
            tr_row = r - 1;
        end
        return 1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    // ---------------- drivers ----------------
    // one input transaction; typed rows override the model's expectation.
    // valid stays up after the accepting edge so items can follow back to back
    task automatic send_item(bit func, rgb_t px, bit typed = 0,
                             seam_result_t want = '0);
        seam_result_t res;
        @(negedge aclk);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= func;
        s_red <= px.red;
        s_green <= px.green;
        s_blue <= px.blue;
        do @(posedge aclk); while (!s_ready);
        if (seam_predict(func, px, res)) expected_seams.push_back(typed ? want : res);
        if (func) steps_sent++;
        else pixels_sent++;
    endtask

    // drop valid after the last accepted transaction
    task automatic idle_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // wait for the block to go quiet, then write one register
    task automatic write_reg(logic idx, int value);
        idle_input();
        wait (expected_seams.size() == 0);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) cfg_width = value[9:0];
        else cfg_height = value[9:0];
        restart_image();
    endtask

    function automatic rgb_t rand_pixel();
        rgb_t p;
        p = 24'($urandom);
        // a narrow palette now and then to provoke ties
        if ($urandom_range(3) == 0) p = {3{8'($urandom_range(1) * 8'hFF)}};
        return p;
    endfunction

    // ---------------- result side ----------------
    initial begin
        seam_result_t exp_r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (expected_seams.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    exp_r = expected_seams.pop_front();
                    if (m_seam_column !== exp_r.column)
                        report_mismatch($sformatf("column %0d, want %0d",
                                                  m_seam_column, exp_r.column));
                    if (m_seam_row !== exp_r.row)
                        report_mismatch($sformatf("row %0d, want %0d", m_seam_row, exp_r.row));
                    if (m_seam_cost !== exp_r.cost)
                        report_mismatch($sformatf("cost %0d, want %0d",
                                                  m_seam_cost, exp_r.cost));
                    if (m_last !== exp_r.last)
                        report_mismatch($sformatf("last %b, want %b", m_last, exp_r.last));
                    if (m_status !== exp_r.status)
                        report_mismatch($sformatf("status %b, want %b",
                                                  m_status, exp_r.status));
                end
            end
            @(negedge aclk);
            if (hold_req > 0) begin
                m_ready <= 1'b0;
                hold_req--;
            end else begin
                m_ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // ---------------- timeout ----------------
    initial begin
        #8000000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------- stimulus ----------------
    stim_row_t dir_tab [$];

    function automatic void tab(row_op_e op, logic idx, int value, rgb_t px,
                                bit typed = 0, seam_result_t want = '0);
        stim_row_t r;
        r.op = op;
        r.reg_idx = idx;
        r.value = value;
        r.pix = px;
        r.typed = typed;
        r.want = want;
        dir_tab.push_back(r);
    endfunction

    initial begin
        seam_result_t early, one_px;
        int w, h, n_steps, total;
        early = '0;
        early.status = 1'b1;
        one_px = '0;
        one_px.last = 1'b1;
        restart_image();
        recent[0] = '0;
        recent[1] = '0;
        tr_col = 0;
        tr_row = 0;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows
        tab(OP_STEP, 0, 0, '0, 1, early);              // seam step right after reset
        tab(OP_CFG, REG_IMAGE_WIDTH, 2, '0);
        tab(OP_CFG, REG_IMAGE_HEIGHT, 2, '0);
        tab(OP_PIX, 0, 0, 24'h000000);
        tab(OP_PIX, 0, 0, 24'hFFFFFF);
        tab(OP_PIX, 0, 0, 24'hFF00FF);
        tab(OP_PIX, 0, 0, 24'h00FF00);
        tab(OP_STEP, 0, 0, '0);
        tab(OP_STEP, 0, 0, '0);
        tab(OP_STEP, 0, 0, '0);                        // replay after the top row
        tab(OP_PIX, 0, 0, 24'h3C5AA5);                 // pixel while tracing: new image
        tab(OP_STEP, 0, 0, '0, 1, early);
        tab(OP_CFG, REG_IMAGE_WIDTH, 0, '0);           // zero acts as one
        tab(OP_CFG, REG_IMAGE_HEIGHT, 1, '0);
        tab(OP_PIX, 0, 0, 24'h123456);
        tab(OP_STEP, 0, 0, '0, 1, one_px);
        tab(OP_STEP, 0, 0, '0, 1, one_px);
        tab(OP_CFG, REG_IMAGE_WIDTH, 3, '0);
        tab(OP_CFG, REG_IMAGE_HEIGHT, 0, '0);
        tab(OP_PIX, 0, 0, 24'h808080);
        tab(OP_PIX, 0, 0, 24'h808080);
        tab(OP_PIX, 0, 0, 24'h808080);
        tab(OP_STEP, 0, 0, '0, 1, one_px);             // flat row: first column wins

        foreach (dir_tab[i]) begin
            case (dir_tab[i].op)
                OP_CFG: write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
                OP_PIX: send_item(1'b0, dir_tab[i].pix);
                default: send_item(1'b1, '0, dir_tab[i].typed, dir_tab[i].want);
            endcase
        end

        // random images, mostly small, two at the size limits
        total = 0;
        for (int img = 0; total < 1200; img++) begin
            idle_pct = (img >= 4 && img < 8) ? 0 : 36;
            case (img)
                3: begin
                    write_reg(REG_IMAGE_WIDTH, 1023);
                    write_reg(REG_IMAGE_HEIGHT, 1);
                end
                7: begin
                    write_reg(REG_IMAGE_WIDTH, 1);
                    write_reg(REG_IMAGE_HEIGHT, 512);
                end
                default: begin
                    // sometimes keep the size, so the next pixel restarts the image
                    if ($urandom_range(3) != 0) begin
                        write_reg(REG_IMAGE_WIDTH, $urandom_range(1, 12));
                        write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 8));
                    end
                end
            endcase
            w = eff_w();
            h = eff_h();
            // early step now and then
            if ($urandom_range(7) == 0) send_item(1'b1, rand_pixel());
            // broken sequence: image cut short by a size write
            if ($urandom_range(9) == 0 && w * h > 2) begin
                repeat ($urandom_range(1, w * h - 1)) send_item(1'b0, rand_pixel());
                write_reg(REG_IMAGE_HEIGHT, h);
            end
            for (int k = 0; k < w * h; k++) send_item(1'b0, rand_pixel());
            n_steps = (h > 20) ? 12 : $urandom_range(h, 2 * h + 3);
            if (img == 2) begin
                // receiver holds off while steps pile up
                hold_req = 150;
                n_steps = 40;
            end
            for (int k = 0; k < n_steps; k++) send_item(1'b1, rand_pixel());
            if (img == 2) begin
                idle_input();
                wait (expected_seams.size() == 0);
            end
            total += w * h + n_steps;
        end

        idle_input();
        wait (expected_seams.size() == 0);
        repeat (20) @(posedge aclk);
        $display("Ran %0d pixel loads and %0d seam steps, %0d results checked.",
                 pixels_sent, steps_sent, results_seen);
        $display("Sizes from 1x1 to full width and full height, random stalls on both sides.");
        if (err_count == 0 && expected_seams.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/seamfe_pkg.sv
rtl/core/seamfe_settle.sv
rtl/core/seam_carving_forward_energy_dp.sv
tb/tb.sv
